@@ rtl/totp_pkg.sv @@
package totp_pkg;

  localparam int KEY_WORDS = 5;
  localparam int MAX_KEY_BYTES = 40;
  localparam int MAX_WINDOW = 15;
  localparam logic [5:0] MAX_KEY_LEN = 6'(MAX_KEY_BYTES);
  localparam logic [3:0] MAX_WIN = 4'(MAX_WINDOW);

  localparam logic [2:0] CFG_KEY_LENGTH = 3'd5;
  localparam logic [2:0] CFG_DIGIT_COUNT = 3'd6;
  localparam logic [2:0] CFG_SKEW_WINDOW = 3'd7;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_VERIFY = 1'b1;

  localparam logic [31:0] DIV_MAGIC_HI = 32'h88888888;
  localparam logic [31:0] DIV_MAGIC_LO = 32'h88888889;

  typedef struct packed {
    logic        opcode;
    logic [63:0] unix_time;
    logic [29:0] candidate_code;
  } totp_in_t;

  typedef struct packed {
    logic [29:0] code;
    logic        valid_res;
  } totp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_HASH,
    ST_NEXTBLK,
    ST_TRUNC,
    ST_MOD,
    ST_CHECK,
    ST_OUT
  } totp_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [29:0] pow_ten(input logic [3:0] d);
    case (d)
      4'd6: pow_ten = 30'd1000000;
      4'd7: pow_ten = 30'd10000000;
      4'd8: pow_ten = 30'd100000000;
      default: pow_ten = 30'd1000000000;
    endcase
  endfunction

endpackage

@@ rtl/totp_generate_verify.sv @@
// TOTP generator/verifier (HMAC-SHA1, 30 s step). Items enter a two-deep queue; the
// back end handles one at a time: it forms the step by reciprocal multiply, then
// per hashed step runs four SHA-1 compressions (load, 80 rounds, feed-forward,
// handoff) and a modular reduction. Generate hashes one step; verify hashes the
// current step and then steps from step-window upward, stopping one step after the
// first match, at most 2*window+2 steps. A waiting result holds the back end.
module totp_generate_verify
  import totp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  totp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output totp_out_t   out_data
);

  logic [63:0] key_word [KEY_WORDS];
  logic [5:0]  key_length;
  logic [3:0]  digit_count;
  logic [3:0]  skew_window;
  logic        q_valid, q_pop;
  totp_in_t    q_data;
  logic [5:0]  key_len_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KEY_WORDS; i++) key_word[i] <= 64'd0;
      key_length <= 6'd20;
      digit_count <= 4'd6;
      skew_window <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LENGTH: key_length <= cfg_data[5:0];
        CFG_DIGIT_COUNT: digit_count <= cfg_data[3:0];
        CFG_SKEW_WINDOW: skew_window <= cfg_data[3:0];
        default: key_word[cfg_index] <= cfg_data;
      endcase
    end
  end

  assign key_len_sat = (key_length > MAX_KEY_LEN) ? MAX_KEY_LEN : key_length;

  totp_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  totp_engine u_engine (
    .clk(clk), .rst(rst),
    .key_bits({key_word[0], key_word[1], key_word[2], key_word[3], key_word[4]}),
    .key_len(key_len_sat), .digits(digit_count), .window(skew_window),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

@@ rtl/totp_queue.sv @@
module totp_queue
  import totp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  totp_in_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output totp_in_t q_data
);

  totp_in_t   mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign pop = q_pop && q_valid;
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/totp_sha1.sv @@
module totp_sha1
  import totp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         init,
  input  logic [511:0] block,
  output logic         done,
  output logic [159:0] digest
);

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] h [5];
  logic [6:0]  round;
  logic        busy;
  logic [31:0] f, k, tmp, wn, wt;

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = 32'h5A827999;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = 32'h6ED9EBA1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = 32'h8F1BBCDC;
    end else begin
      f = b ^ c ^ d;
      k = 32'hCA62C1D6;
    end
    wt = w[0];
    tmp = rotl(a, 5) + f + e + k + wt;
    wn = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  end

  assign digest = {h[0], h[1], h[2], h[3], h[4]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      round <= 7'd0;
    end else if (start) begin
      busy <= 1'b1;
      round <= 7'd0;
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[511 - 32*i -: 32];
      end
      if (init) begin
        h[0] <= 32'h67452301; h[1] <= 32'hEFCDAB89; h[2] <= 32'h98BADCFE;
        h[3] <= 32'h10325476; h[4] <= 32'hC3D2E1F0;
        a <= 32'h67452301; b <= 32'hEFCDAB89; c <= 32'h98BADCFE;
        d <= 32'h10325476; e <= 32'hC3D2E1F0;
      end else begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end
    end else if (busy) begin
      if (round == 7'd80) begin
        h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
        h[3] <= h[3] + d; h[4] <= h[4] + e;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i + 1];
        end
        w[15] <= wn;
        e <= d; d <= c; c <= rotl(b, 30); b <= a; a <= tmp;
        round <= round + 7'd1;
      end
    end
  end

endmodule

@@ rtl/totp_engine.sv @@
module totp_engine
  import totp_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic [319:0]    key_bits,
  input  logic [5:0]      key_len,
  input  logic [3:0]      digits,
  input  logic [3:0]      window,
  input  logic            q_valid,
  output logic            q_pop,
  input  totp_in_t        q_data,
  output logic            out_valid,
  input  logic            out_stall,
  output totp_out_t       out_data
);

  totp_state_t state, state_next;
  logic [63:0]  quot;
  logic [65:0]  acc;
  logic [31:0]  mul_a;
  logic [31:0]  mul_b;
  logic [63:0]  prod;
  logic [2:0]   bitcnt;
  logic [63:0]  step;
  logic [63:0]  cur_step;
  logic [4:0]   idx;
  logic [4:0]   last_idx;
  logic         verify;
  logic [29:0]  cand;
  logic [29:0]  modulus;
  logic [1:0]   blk;
  logic [159:0] inner;
  logic [511:0] kpad;
  logic [511:0] blk_data;
  logic         sha_start, sha_init, sha_done;
  logic [159:0] digest;
  logic [31:0]  bin;
  logic [61:0]  mrem;
  logic [5:0]   mcnt;
  logic [29:0]  cur_code;
  logic         match;
  totp_out_t    res;
  logic         out_full;
  logic [3:0]   off;
  logic [7:0]   mb [20];
  logic [63:0]  win64;
  logic         res_valid;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      if (i < 40 && 6'(i) < key_len) kpad[511 - 8*i -: 8] = key_bits[319 - 8*i -: 8];
      else kpad[511 - 8*i -: 8] = 8'h00;
    end
    case (blk)
      2'd0: blk_data = kpad ^ {64{8'h36}};
      2'd1: blk_data = {step, 8'h80, 376'd0, 64'd576};
      2'd2: blk_data = kpad ^ {64{8'h5C}};
      default: blk_data = {inner, 8'h80, 280'd0, 64'd672};
    endcase
    for (int i = 0; i < 20; i++) mb[i] = digest[159 - 8*i -: 8];
    off = mb[19][3:0];
    bin = {1'b0, mb[off][6:0], mb[5'(off) + 5'd1], mb[5'(off) + 5'd2], mb[5'(off) + 5'd3]};
    win64 = {60'd0, window};
    mul_a = bitcnt[1] ? quot[63:32] : quot[31:0];
    mul_b = bitcnt[0] ? DIV_MAGIC_HI : DIV_MAGIC_LO;
    prod = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    sha_start = 1'b0;
    sha_init = 1'b0;
    case (state)
      ST_IDLE: if (q_valid) state_next = ST_DIV;
      ST_DIV: if (bitcnt == 3'd4) state_next = ST_LOAD;
      ST_LOAD: begin
        sha_start = 1'b1;
        sha_init = (blk == 2'd0) || (blk == 2'd2);
        state_next = ST_HASH;
      end
      ST_HASH: if (sha_done) state_next = (blk == 2'd3) ? ST_TRUNC : ST_NEXTBLK;
      ST_NEXTBLK: state_next = ST_LOAD;
      ST_TRUNC: state_next = ST_MOD;
      ST_MOD: if (mcnt == 6'd32) state_next = ST_CHECK;
      ST_CHECK: begin
        if (!verify || idx == last_idx || match) state_next = ST_OUT;
        else state_next = ST_LOAD;
      end
      ST_OUT: if (!out_full) begin
        q_pop = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        quot <= q_data.unix_time;
        acc <= 66'd0;
        bitcnt <= 3'd0;
        verify <= (q_data.opcode == OP_VERIFY);
        cand <= q_data.candidate_code;
        modulus <= pow_ten((digits < 4'd6) ? 4'd6 : (digits > 4'd9) ? 4'd9 : digits);
        last_idx <= 5'({(window > MAX_WIN ? MAX_WIN : window), 1'b0}) + 5'd1;
        idx <= 5'd0;
        match <= 1'b0;
        blk <= 2'd0;
      end
      ST_DIV: begin
        case (bitcnt)
          3'd0: acc <= {2'b00, prod};
          3'd1, 3'd3: acc <= {32'd0, acc[65:32]} + {2'b00, prod};
          3'd2: acc <= acc + {2'b00, prod};
          default: begin
            cur_step <= {4'd0, acc[63:4]};
            step <= {4'd0, acc[63:4]};
          end
        endcase
        if (bitcnt != 3'd4) bitcnt <= bitcnt + 3'd1;
      end
      ST_NEXTBLK: begin
        if (blk == 2'd1) inner <= digest;
        blk <= blk + 2'd1;
      end
      ST_TRUNC: begin
        mrem <= {30'd0, bin};
        mcnt <= 6'd0;
      end
      ST_MOD: begin
        if (mcnt != 6'd32) begin
          if (mrem[61:31] >= {1'b0, modulus})
            mrem <= {mrem[61:31] - {1'b0, modulus}, mrem[30:0]} << 1;
          else mrem <= mrem << 1;
          mcnt <= mcnt + 6'd1;
        end
      end
      ST_CHECK: begin
        if (idx == 5'd0) cur_code <= mrem[61:32];
        else if (mrem[61:32] == cand) match <= 1'b1;
        idx <= idx + 5'd1;
        blk <= 2'd0;
        step <= cur_step - (win64 > 64'(MAX_WINDOW) ? 64'(MAX_WINDOW) : win64)
                + 64'(idx);
      end
      default: ;
    endcase
  end

  totp_sha1 u_sha1 (
    .clk(clk), .rst(rst), .start(sha_start), .init(sha_init),
    .block(blk_data), .done(sha_done), .digest(digest)
  );

  assign res.code = cur_code;
  assign res.valid_res = match;
  assign out_full = out_valid && out_stall;
  assign out_valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (state == ST_OUT && !out_full) res_valid <= 1'b1;
    else if (!out_stall) res_valid <= 1'b0;
    if (state == ST_OUT && !out_full) out_data <= res;
  end

endmodule

@@ tb/totp_generate_verify_test.sv @@
`timescale 1ns / 100ps

module totp_generate_verify_test;
  import totp_pkg::*;

  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  totp_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  totp_out_t   out_data;

  totp_generate_verify dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  logic [63:0] key_bank [KEY_WORDS];
  logic [5:0]  key_len;
  logic [3:0]  digits;
  logic [3:0]  window;

  totp_in_t  pending_items[$];
  totp_out_t expected_codes[$];
  int        error_count;
  bit        idle_on;

  function automatic logic [159:0] sha1_compress(input logic [159:0] h,
                                                 input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 80; i++) begin
      x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
      w[i] = {x[30:0], x[31]};
    end
    a = h[159:128]; b = h[127:96]; c = h[95:64]; d = h[63:32]; e = h[31:0];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
    end
    return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
  endfunction

  function automatic logic [159:0] sha1_two(input logic [511:0] first, input logic [511:0] last);
    logic [159:0] h;
    h = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
    h = sha1_compress(h, first);
    return sha1_compress(h, last);
  endfunction

  function automatic logic [29:0] step_code(input logic [63:0] step);
    logic [511:0] kpad, mask;
    logic [159:0] inner, mac;
    logic [31:0]  bin;
    logic [3:0]   off;
    logic [3:0]   d;
    int           len;
    len = (key_len > MAX_KEY_LEN) ? MAX_KEY_BYTES : int'(key_len);
    mask = ~({512{1'b1}} >> (8 * len));
    kpad = {key_bank[0], key_bank[1], key_bank[2], key_bank[3], key_bank[4], 192'b0} & mask;
    inner = sha1_two(kpad ^ {64{8'h36}}, {step, 8'h80, 376'b0, 64'd576});
    mac = sha1_two(kpad ^ {64{8'h5C}}, {inner, 8'h80, 280'b0, 64'd672});
    off = mac[3:0];
    bin = mac[159 - 8 * off -: 32] & 32'h7FFFFFFF;
    d = (digits < 4'd6) ? 4'd6 : (digits > 4'd9) ? 4'd9 : digits;
    return 30'(bin % pow_ten(d));
  endfunction

  function automatic totp_out_t predict_result(input totp_in_t item);
    totp_out_t   r;
    logic [63:0] step;
    logic [63:0] w;
    step = item.unix_time / 64'd30;
    w = (window > MAX_WIN) ? 64'(MAX_WIN) : 64'(window);
    r.code = step_code(step);
    r.valid_res = 1'b0;
    if (item.opcode == OP_VERIFY)
      for (logic [63:0] i = 0; i <= 2 * w && !r.valid_res; i++)
        if (step_code(step - w + i) == item.candidate_code) r.valid_res = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() != 0 && !(idle_on && $urandom_range(99) < 20)) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idle_on && ($urandom_range(99) < 20);
  end

  always @(posedge clk) begin
    totp_out_t want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_codes.push_back(predict_result(in_data));
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          report_mismatch("unexpected item", out_data.code, 0);
        end else begin
          want = expected_codes.pop_front();
          if (out_data.code !== want.code) report_mismatch("code", out_data.code, want.code);
          if (out_data.valid_res !== want.valid_res)
            report_mismatch("valid_res", out_data.valid_res, want.valid_res);
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx < CFG_KEY_LENGTH) key_bank[idx] = value;
    else if (idx == CFG_KEY_LENGTH) key_len = value[5:0];
    else if (idx == CFG_DIGIT_COUNT) digits = value[3:0];
    else window = value[3:0];
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_codes.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic totp_in_t random_item();
    totp_in_t    item;
    logic [63:0] step;
    int          w, pick;
    item.opcode = 1'($urandom_range(1));
    item.unix_time = ($urandom_range(3) == 0) ? 64'($urandom_range(300))
                                              : {$urandom, $urandom};
    item.candidate_code = 30'($urandom);
    pick = $urandom_range(9);
    if (item.opcode == OP_VERIFY && pick < 7) begin
      step = item.unix_time / 64'd30;
      w = int'(window);
      item.candidate_code = step_code(step + 64'($urandom_range(2 * w + 2)) - 64'(w + 1));
    end else if (pick == 7) begin
      item.candidate_code = 30'($urandom_range(999999999));
    end
    return item;
  endfunction

  function automatic totp_in_t make_item(input logic op, input logic [63:0] t,
                                         input logic [29:0] cand);
    totp_in_t item;
    item.opcode = op;
    item.unix_time = t;
    item.candidate_code = cand;
    return item;
  endfunction

  initial begin
    logic [5:0] lens [6];
    logic [3:0] digs [6];
    logic [3:0] wins [10];
    int         count;
    lens = '{6'd20, 6'd0, 6'd1, 6'd40, 6'd63, 6'd33};
    digs = '{4'd6, 4'd9, 4'd7, 4'd0, 4'd15, 4'd8};
    wins = '{4'd1, 4'd0, 4'd2, 4'd15, 4'd1, 4'd0, 4'd3, 4'd2, 4'd1, 4'd0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    error_count = 0;
    for (int i = 0; i < KEY_WORDS; i++) key_bank[i] = '0;
    key_len = 6'd20;
    digits = 4'd6;
    window = 4'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    pending_items.push_back(make_item(OP_GENERATE, 64'd0, 30'd0));
    pending_items.push_back(make_item(OP_VERIFY, 64'd0, step_code(64'hFFFF_FFFF_FFFF_FFFF)));
    pending_items.push_back(make_item(OP_VERIFY, 64'd29, 30'h3FFF_FFFF));
    pending_items.push_back(make_item(OP_GENERATE, 64'hFFFF_FFFF_FFFF_FFFF, 30'h3FFF_FFFF));
    drain();

    write_reg(CFG_KEY_WORD_0, 64'h3132333435363738);
    write_reg(CFG_KEY_WORD_0 + 3'd1, 64'h3930313233343536);
    write_reg(CFG_KEY_WORD_0 + 3'd2, 64'h3738393000000000);
    write_reg(CFG_DIGIT_COUNT, 64'd8);
    end_writes();
    pending_items.push_back(make_item(OP_GENERATE, 64'd59, 30'd0));
    pending_items.push_back(make_item(OP_VERIFY, 64'd59, step_code(64'd1)));
    pending_items.push_back(make_item(OP_VERIFY, 64'd89, step_code(64'd1)));
    pending_items.push_back(make_item(OP_VERIFY, 64'd119, step_code(64'd1)));
    pending_items.push_back(make_item(OP_VERIFY, 64'd30, 30'd999999999));
    pending_items.push_back(make_item(OP_VERIFY, 64'hFFFF_FFFF_FFFF_FFFF, 30'h3FFF_FFFF));
    pending_items.push_back(make_item(OP_GENERATE, 64'd1111111109, 30'h2AAA_AAAA));
    pending_items.push_back(make_item(OP_VERIFY, 64'd2000000000, 30'h1555_5555));
    drain();

    for (int p = 0; p < 10; p++) begin
      for (int i = 0; i < KEY_WORDS; i++)
        write_reg(CFG_KEY_WORD_0 + 3'(i), (p == 1) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                    : {$urandom, $urandom});
      write_reg(CFG_KEY_LENGTH, {$urandom, 26'b0, lens[p % 6]});
      write_reg(CFG_DIGIT_COUNT, {$urandom, 28'b0, digs[p % 6]});
      write_reg(CFG_SKEW_WINDOW, {$urandom, 28'b0, wins[p]});
      end_writes();
      idle_on = !(p == 5 || p == 6);
      count = (wins[p] == 4'd15) ? 6 : 64;
      for (int n = 0; n < count; n++) pending_items.push_back(random_item());
      drain();
    end

    repeat (50) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/totp_pkg.sv
rtl/totp_queue.sv
rtl/totp_sha1.sv
rtl/totp_engine.sv
rtl/totp_generate_verify.sv
tb/totp_generate_verify_test.sv
